// ===== rtl/grid_likelihood_field_map_core_assert.svh =====
// ============================================================================
// Grid likelihood field map assertion macros
// Shorthand for clocked implication checks used by the map's controller.
// ============================================================================
`ifndef GRID_LIKELIHOOD_FIELD_MAP_CORE_ASSERT_SVH
`define GRID_LIKELIHOOD_FIELD_MAP_CORE_ASSERT_SVH

// Same-cycle implication under reset.
`define GLFM_ASSERT_IMP(label, clk_sig, rst_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
        else $error("glfm check failed");

// Next-cycle implication under reset.
`define GLFM_ASSERT_NXT(label, clk_sig, rst_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |=> (cons)) \
        else $error("glfm check failed");

`endif

// ===== rtl/glfm_pkg.sv =====
// ============================================================================
// Grid likelihood field map package
// Shared types, command and register codes, and constants of the map.
// ============================================================================
`default_nettype none

package glfm_pkg;

    localparam int DIM_W     = 13;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;
    localparam int LIK_W     = 6;

    localparam logic [6:0]       OCC_THRESHOLD = 7'd50;
    localparam logic [LIK_W-1:0] LIK_MAX       = 6'd63;

    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_LOAD  = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_POS_X    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_POS_Y    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CELLS_PER_METRE = 3'd4;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_STAMP,
        ST_DRAIN,
        ST_Q_DIFF,
        ST_Q_MUL_X,
        ST_Q_AXIS_X,
        ST_Q_AXIS_Y,
        ST_Q_READ,
        ST_Q_OUT
    } glfm_state_t;

    typedef struct packed {
        logic [8:0]  grid_width;
        logic [8:0]  grid_height;
        logic [31:0] origin_pos_x;
        logic [31:0] origin_pos_y;
        logic [31:0] cells_per_metre;
    } glfm_cfg_t;

    typedef struct packed {
        logic clear_step;
        logic start_take;
        logic load_take;
        logic stamp_step;
        logic query_take;
        logic diff_en;
        logic mul_x;
        logic mul_y;
        logic eval_x;
        logic eval_y;
        logic query_rd;
        logic out_load;
    } glfm_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic load_hit;
        logic stamp_last;
        logic out_busy;
    } glfm_sts_t;

endpackage

`default_nettype wire

// ===== rtl/glfm_ctrl.sv =====
// ============================================================================
// Grid likelihood field map controller
// Sequences clearing, neighborhood stamping and the query steps.
// ============================================================================
`default_nettype none

`include "grid_likelihood_field_map_core_assert.svh"

module glfm_ctrl
    import glfm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] command,
    input  glfm_sts_t  sts,
    output glfm_cmd_t  cmd
);

    glfm_state_t state_reg;
    glfm_state_t state_next;
    logic        accept;

    assign accept = in_valid && (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (sts.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (command)
                        CMD_START: state_next = ST_CLEAR;
                        CMD_LOAD:  state_next = sts.load_hit ? ST_STAMP : ST_IDLE;
                        CMD_QUERY: state_next = ST_Q_DIFF;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_STAMP:
            begin
                if (sts.stamp_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:    state_next = ST_IDLE;
            ST_Q_DIFF:   state_next = ST_Q_MUL_X;
            ST_Q_MUL_X:  state_next = ST_Q_AXIS_X;
            ST_Q_AXIS_X: state_next = ST_Q_AXIS_Y;
            ST_Q_AXIS_Y: state_next = ST_Q_READ;
            ST_Q_READ:   state_next = ST_Q_OUT;
            ST_Q_OUT:
            begin
                if (!sts.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        in_stall       = 1'b1;
        unique case (state_reg)
            ST_CLEAR:    cmd.clear_step = 1'b1;
            ST_IDLE:
            begin
                in_stall       = 1'b0;
                cmd.start_take = accept && (command == CMD_START);
                cmd.load_take  = accept && (command == CMD_LOAD);
                cmd.query_take = accept && (command == CMD_QUERY);
            end
            ST_STAMP:    cmd.stamp_step = 1'b1;
            ST_DRAIN:    cmd = '0;
            ST_Q_DIFF:   cmd.diff_en = 1'b1;
            ST_Q_MUL_X:  cmd.mul_x = 1'b1;
            ST_Q_AXIS_X:
            begin
                cmd.mul_y  = 1'b1;
                cmd.eval_x = 1'b1;
            end
            ST_Q_AXIS_Y: cmd.eval_y = 1'b1;
            ST_Q_READ:   cmd.query_rd = 1'b1;
            ST_Q_OUT:    cmd.out_load = !sts.out_busy;
            default:     cmd = '0;
        endcase
    end

    `GLFM_ASSERT_NXT(a_start_clears, clk, rst_n, accept && (command == CMD_START), state_reg == ST_CLEAR)
    `GLFM_ASSERT_NXT(a_stamp_drains, clk, rst_n, (state_reg == ST_STAMP) && sts.stamp_last, state_reg == ST_DRAIN)
    `GLFM_ASSERT_NXT(a_result_idle, clk, rst_n, (state_reg == ST_Q_OUT) && !sts.out_busy, state_reg == ST_IDLE)

endmodule

`default_nettype wire

// ===== rtl/glfm_datapath.sv =====
// ============================================================================
// Grid likelihood field map datapath
// Map memory, raster load counters, stamp pipeline, query arithmetic and
// the result register.
// ============================================================================
`default_nettype none

module glfm_datapath
    import glfm_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  glfm_cfg_t         cfg,
    input  glfm_cmd_t         cmd,
    output glfm_sts_t         sts,
    input  logic [7:0]        cell_value,
    input  logic [31:0]       pos_x,
    input  logic [31:0]       pos_y,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [LIK_W-1:0]  likelihood_quarters,
    output logic              occupied,
    output logic              inside_res,
    output logic signed [8:0] cell_x,
    output logic signed [8:0] cell_y
);

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int AW    = XW + YW;
    localparam int DEPTH = 1 << AW;
    localparam int WORD_W = LIK_W + 1;
    localparam logic [DIM_W-1:0] MAX_W_D = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] MAX_H_D = DIM_W'(MAX_HEIGHT);

    logic [WORD_W-1:0] mem [0:DEPTH-1];
    logic [WORD_W-1:0] rd_data_reg;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [WORD_W-1:0] wr_data;

    logic [DIM_W-1:0] w_used;
    logic [DIM_W-1:0] h_used;

    logic [AW-1:0] clr_cnt_reg;

    logic [DIM_W-1:0] load_x_reg;
    logic [DIM_W-1:0] load_y_reg;
    logic [DIM_W-1:0] load_x_next;
    logic [DIM_W-1:0] load_y_next;
    logic             ok0;
    logic             ok1;
    logic             wrap;
    logic [DIM_W-1:0] cx;
    logic [DIM_W-1:0] cy;
    logic [DIM_W-1:0] cx_inc;

    logic [DIM_W-1:0] cx_reg;
    logic [DIM_W-1:0] cy_reg;
    logic [2:0]       dx_reg;
    logic [2:0]       dy_reg;
    logic [DIM_W:0]   sx;
    logic [DIM_W:0]   sy;
    logic [DIM_W:0]   ngb_x;
    logic [DIM_W:0]   ngb_y;
    logic             ngb_in;
    logic [1:0]       ax;
    logic [1:0]       ay;
    logic [1:0]       ring;
    logic [1:0]       inc;
    logic [AW-1:0]    ngb_addr;

    logic             stage_valid_reg;
    logic [AW-1:0]    stage_addr_reg;
    logic [1:0]       stage_inc_reg;
    logic             stage_center_reg;
    logic [LIK_W:0]   lik_sum;
    logic [LIK_W-1:0] lik_sat;

    logic [31:0] qpos_x_reg;
    logic [31:0] qpos_y_reg;
    logic [32:0] diff_x;
    logic [32:0] diff_y;
    logic [32:0] mag_x_reg;
    logic [32:0] mag_y_reg;
    logic        neg_x_reg;
    logic        neg_y_reg;
    logic [31:0] mul_a;
    logic [63:0] prod_reg;
    logic        prod_hi_reg;
    logic        prod_neg_reg;
    logic [31:0] idx_full;
    logic        prod_nonzero;
    logic [DIM_W-1:0] axis_lim;
    logic        axis_in;
    logic        qx_in_reg;
    logic        qy_in_reg;
    logic [DIM_W-1:0] qx_idx_reg;
    logic [DIM_W-1:0] qy_idx_reg;
    logic [AW-1:0]    query_addr;

    logic              out_valid_reg;
    logic [LIK_W-1:0]  out_lik_reg;
    logic              out_occ_reg;
    logic              out_inside_reg;
    logic [8:0]        out_cx_reg;
    logic [8:0]        out_cy_reg;

    assign w_used = ({4'b0, cfg.grid_width} > MAX_W_D) ? MAX_W_D : {4'b0, cfg.grid_width};
    assign h_used = ({4'b0, cfg.grid_height} > MAX_H_D) ? MAX_H_D : {4'b0, cfg.grid_height};

    // Raster load bookkeeping.
    always_comb
    begin
        ok0    = (w_used != '0) && (h_used != '0) && (load_y_reg < h_used);
        wrap   = load_x_reg >= w_used;
        cx     = wrap ? '0 : load_x_reg;
        cy     = wrap ? load_y_reg + 1'b1 : load_y_reg;
        ok1    = ok0 && (cy < h_used);
        cx_inc = cx + 1'b1;
        if (!ok0)
        begin
            load_x_next = load_x_reg;
            load_y_next = load_y_reg;
        end
        else if (!ok1)
        begin
            load_x_next = '0;
            load_y_next = cy;
        end
        else if (cx_inc >= w_used)
        begin
            load_x_next = '0;
            load_y_next = cy + 1'b1;
        end
        else
        begin
            load_x_next = cx_inc;
            load_y_next = cy;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_x_reg  <= '0;
            load_y_reg  <= '0;
            clr_cnt_reg <= '0;
            dx_reg      <= '0;
            dy_reg      <= '0;
        end
        else
        begin
            if (cmd.start_take)
            begin
                load_x_reg  <= '0;
                load_y_reg  <= '0;
                clr_cnt_reg <= '0;
            end
            else
            begin
                if (cmd.load_take)
                begin
                    load_x_reg <= load_x_next;
                    load_y_reg <= load_y_next;
                end
                if (cmd.clear_step)
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                end
            end
            if (cmd.load_take)
            begin
                dx_reg <= '0;
                dy_reg <= '0;
            end
            else if (cmd.stamp_step)
            begin
                if (dx_reg == 3'd4)
                begin
                    dx_reg <= '0;
                    dy_reg <= dy_reg + 1'b1;
                end
                else
                begin
                    dx_reg <= dx_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_take)
        begin
            cx_reg <= cx;
            cy_reg <= cy;
        end
    end

    // Neighborhood walk: the weight is three minus the ring distance.
    always_comb
    begin
        sx     = {1'b0, cx_reg} + {{(DIM_W-2){1'b0}}, dx_reg};
        sy     = {1'b0, cy_reg} + {{(DIM_W-2){1'b0}}, dy_reg};
        ngb_x  = sx - 2'd2;
        ngb_y  = sy - 2'd2;
        ngb_in = (sx >= 2) && (ngb_x < {1'b0, w_used})
              && (sy >= 2) && (ngb_y < {1'b0, h_used});
        ax     = (dx_reg == 3'd2) ? 2'd0
               : ((dx_reg == 3'd1) || (dx_reg == 3'd3)) ? 2'd1 : 2'd2;
        ay     = (dy_reg == 3'd2) ? 2'd0
               : ((dy_reg == 3'd1) || (dy_reg == 3'd3)) ? 2'd1 : 2'd2;
        ring   = (ax > ay) ? ax : ay;
        inc    = 2'd3 - ring;
        ngb_addr = {ngb_y[YW-1:0], ngb_x[XW-1:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= cmd.stamp_step && ngb_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.stamp_step)
        begin
            stage_addr_reg   <= ngb_addr;
            stage_inc_reg    <= inc;
            stage_center_reg <= (ring == 2'd0);
        end
    end

    assign lik_sum = {1'b0, rd_data_reg[LIK_W-1:0]} + {{(LIK_W-1){1'b0}}, stage_inc_reg};
    assign lik_sat = (lik_sum > {1'b0, LIK_MAX}) ? LIK_MAX : lik_sum[LIK_W-1:0];

    // Query arithmetic.
    assign diff_x = {qpos_x_reg[31], qpos_x_reg} - {cfg.origin_pos_x[31], cfg.origin_pos_x};
    assign diff_y = {qpos_y_reg[31], qpos_y_reg} - {cfg.origin_pos_y[31], cfg.origin_pos_y};
    assign mul_a  = cmd.mul_y ? mag_y_reg[31:0] : mag_x_reg[31:0];

    always_ff @(posedge clk)
    begin
        if (cmd.query_take)
        begin
            qpos_x_reg <= pos_x;
            qpos_y_reg <= pos_y;
        end
        if (cmd.diff_en)
        begin
            neg_x_reg <= diff_x[32];
            neg_y_reg <= diff_y[32];
            mag_x_reg <= diff_x[32] ? (33'd0 - diff_x) : diff_x;
            mag_y_reg <= diff_y[32] ? (33'd0 - diff_y) : diff_y;
        end
        if (cmd.mul_x || cmd.mul_y)
        begin
            prod_reg     <= 64'(mul_a) * 64'(cfg.cells_per_metre);
            prod_hi_reg  <= cmd.mul_y ? mag_y_reg[32] : mag_x_reg[32];
            prod_neg_reg <= cmd.mul_y ? neg_y_reg : neg_x_reg;
        end
        if (cmd.eval_x)
        begin
            qx_in_reg  <= axis_in;
            qx_idx_reg <= idx_full[DIM_W-1:0];
        end
        if (cmd.eval_y)
        begin
            qy_in_reg  <= axis_in;
            qy_idx_reg <= idx_full[DIM_W-1:0];
        end
    end

    // A magnitude of exactly two to the 32 has a zero low word.
    assign idx_full     = prod_hi_reg ? cfg.cells_per_metre : prod_reg[63:32];
    assign prod_nonzero = prod_hi_reg ? (cfg.cells_per_metre != '0) : (prod_reg != '0);
    assign axis_lim     = cmd.eval_y ? h_used : w_used;
    assign axis_in      = !(prod_neg_reg && prod_nonzero)
                       && (idx_full < {{(32-DIM_W){1'b0}}, axis_lim});
    assign query_addr   = {qy_idx_reg[YW-1:0], qx_idx_reg[XW-1:0]};

    // Map memory: one write and one registered read per cycle.
    assign rd_en   = (cmd.stamp_step && ngb_in) || cmd.query_rd;
    assign rd_addr = cmd.query_rd ? query_addr : ngb_addr;
    assign wr_en   = cmd.clear_step || stage_valid_reg;
    assign wr_addr = cmd.clear_step ? clr_cnt_reg : stage_addr_reg;
    assign wr_data = cmd.clear_step ? '0 : {rd_data_reg[LIK_W] | stage_center_reg, lik_sat};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_inside_reg <= qx_in_reg && qy_in_reg;
            out_lik_reg    <= (qx_in_reg && qy_in_reg) ? rd_data_reg[LIK_W-1:0] : '0;
            out_occ_reg    <= qx_in_reg && qy_in_reg && rd_data_reg[LIK_W];
            out_cx_reg     <= qx_in_reg ? qx_idx_reg[8:0] : '1;
            out_cy_reg     <= qy_in_reg ? qy_idx_reg[8:0] : '1;
        end
    end

    assign sts.clear_last = &clr_cnt_reg;
    assign sts.load_hit   = ok1 && !cell_value[7] && (cell_value[6:0] > OCC_THRESHOLD);
    assign sts.stamp_last = (dx_reg == 3'd4) && (dy_reg == 3'd4);
    assign sts.out_busy   = out_valid_reg && out_stall;

    assign out_valid           = out_valid_reg;
    assign likelihood_quarters = out_lik_reg;
    assign occupied            = out_occ_reg;
    assign inside_res          = out_inside_reg;
    assign cell_x              = $signed(out_cx_reg);
    assign cell_y              = $signed(out_cy_reg);

endmodule

`default_nettype wire

// ===== rtl/grid_likelihood_field_map_core.sv =====
// ============================================================================
// Grid likelihood field map core
// Occupancy grid with a likelihood field for localization: raster loading
// with neighborhood stamping, and fixed-point position queries.
// ============================================================================
// The map lives in one memory with a single write and a single registered
// read port, and that port sets the timing. After reset, and after every
// start word, the memory is swept clear one entry per cycle (65536 entries
// at the default 256 by 256 size, 2 to the power of clog2(MAX_WIDTH) plus
// clog2(MAX_HEIGHT) in general); no input word is taken meanwhile, though
// register writes are. For a load word of an occupied cell the 5x5
// neighborhood is read and written back one cell per cycle, then a drain
// step finishes the last write; other load words do not stamp. A query word
// passes the difference, X multiply, X axis, Y axis and read steps, then its
// result enters an output register, and the next word can be taken in the
// following cycle while that result still waits. A query holds in its output
// step only while the previous result has not yet been handed on.
`default_nettype none

module grid_likelihood_field_map_core
    import glfm_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           command,
    input  logic signed [7:0]    cell_value,
    input  logic signed [31:0]   pos_x,
    input  logic signed [31:0]   pos_y,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [LIK_W-1:0]     likelihood_quarters,
    output logic                 occupied,
    output logic                 inside_res,
    output logic signed [8:0]    cell_x,
    output logic signed [8:0]    cell_y
);

    glfm_cfg_t cfg_reg;
    glfm_cmd_t cmd;
    glfm_sts_t sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.grid_width      <= 9'd256;
            cfg_reg.grid_height     <= 9'd256;
            cfg_reg.origin_pos_x    <= '0;
            cfg_reg.origin_pos_y    <= '0;
            cfg_reg.cells_per_metre <= 32'd1310720;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_GRID_WIDTH:      cfg_reg.grid_width      <= cfg_data[8:0];
                REG_GRID_HEIGHT:     cfg_reg.grid_height     <= cfg_data[8:0];
                REG_ORIGIN_POS_X:    cfg_reg.origin_pos_x    <= cfg_data;
                REG_ORIGIN_POS_Y:    cfg_reg.origin_pos_y    <= cfg_data;
                REG_CELLS_PER_METRE: cfg_reg.cells_per_metre <= cfg_data;
                default:             cfg_reg <= cfg_reg;
            endcase
        end
    end

    glfm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .command  (command),
        .sts      (sts),
        .cmd      (cmd)
    );

    glfm_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg                 (cfg_reg),
        .cmd                 (cmd),
        .sts                 (sts),
        .cell_value          (cell_value),
        .pos_x               (pos_x),
        .pos_y               (pos_y),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .likelihood_quarters (likelihood_quarters),
        .occupied            (occupied),
        .inside_res          (inside_res),
        .cell_x              (cell_x),
        .cell_y              (cell_y)
    );

endmodule

`default_nettype wire
